// ----- sv/pingpong_dirty_snapshot_store_defines.svh -----
// Assertion macros shared by the store's modules
`ifndef PINGPONG_DIRTY_SNAPSHOT_STORE_DEFINES_SVH
`define PINGPONG_DIRTY_SNAPSHOT_STORE_DEFINES_SVH

// Check a same-cycle implication outside reset
`define PDSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdss: same-cycle check failed");

// Check a next-cycle implication outside reset
`define PDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdss: next-cycle check failed");

`endif

// ----- sv/pdss_pkg.sv -----
// Shared types and constants of the ping-pong dirty snapshot store
package pdss_pkg;

    // Field widths of one input word and one result word
    localparam int CMD_BITS  = 2;
    localparam int IDX_BITS  = 31;
    localparam int DATA_BITS = 32;

    // Stream word widths, padded to whole bytes
    localparam int IN_TDATA_BITS  = ((IDX_BITS + DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((DATA_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - DATA_BITS - 1;

    // Default geometry
    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_WORD_BITS   = 32;

    // Reset fill byte of every stored word
    localparam logic [7:0] FILL_BYTE = 8'h53;

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_READ       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_CHECKPOINT = 2'd2,
        CMD_SNAP_READ  = 2'd3
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input word
        logic step;    // one index reduction step
        logic access;  // perform the read or write at the slot
        logic flip;    // toggle the active copy
        logic sweep;   // write reset values at the pointer
        logic walk;    // read the inactive copy at the pointer
        logic finish;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic red_done;
        logic ptr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/pdss_dp.sv -----
// Datapath: word stores with dirty bits, snapshot store, index reduction, result register
`include "pingpong_dirty_snapshot_store_defines.svh"

module pdss_dp #(
    parameter int STORE_DEPTH = pdss_pkg::DEF_STORE_DEPTH,
    parameter int WORD_BITS   = pdss_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pdss_pkg::t_dp_cmd            i_cmd,
    output pdss_pkg::t_dp_sts            o_sts,
    input  pdss_pkg::t_cmd               i_in_cmd,
    input  logic [pdss_pkg::IDX_BITS-1:0]  i_in_idx,
    input  logic [pdss_pkg::DATA_BITS-1:0] i_in_wdata,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [pdss_pkg::DATA_BITS-1:0] o_out_data,
    output logic                         o_out_active
);
    import pdss_pkg::*;

    localparam int  AW         = $clog2(STORE_DEPTH);
    localparam bit  DEPTH_POW2 = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
    localparam logic [WORD_BITS-1:0] FILL_WORD = WORD_BITS'({8{FILL_BYTE}});

    // Stores: copies carry the dirty bit on top of the word
    logic [WORD_BITS:0]   r_mem_zero [STORE_DEPTH];
    logic [WORD_BITS:0]   r_mem_one  [STORE_DEPTH];
    logic [WORD_BITS-1:0] r_mem_snap [STORE_DEPTH];

    logic [WORD_BITS:0]   r_q_zero;
    logic [WORD_BITS:0]   r_q_one;
    logic [WORD_BITS-1:0] r_q_snap;

    t_cmd                 r_cmd;
    logic [DATA_BITS-1:0] r_wdata;
    logic                 r_active;
    logic [AW-1:0]        r_ptr;
    logic                 r_wb_vld;
    logic [AW-1:0]        r_wb_addr;
    logic                 r_out_vld;
    logic [DATA_BITS-1:0] r_out_data;
    logic                 r_out_active;

    logic [AW-1:0]        w_slot;
    logic                 w_red_done;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_wr_zero;
    logic                 w_wr_one;
    logic [WORD_BITS:0]   w_wb_entry;
    logic                 w_wb_zero;
    logic                 w_wb_one;
    logic                 w_wb_snap;
    logic [DATA_BITS-1:0] w_result;
    logic                 w_ptr_last;

    // Reduce the index modulo the depth
    generate
        if (DEPTH_POW2) begin : g_mask
            logic [AW-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_idx <= i_in_idx[AW-1:0];
                end
            end

            assign w_slot     = r_idx;
            assign w_red_done = 1'b1;
        end else begin : g_div
            localparam int CW = 3;
            localparam logic [IDX_BITS-1:0] RECIP =
                IDX_BITS'((64'd1 << IDX_BITS) / STORE_DEPTH);
            localparam logic [IDX_BITS-1:0] DEPTH_IDX = IDX_BITS'(STORE_DEPTH);

            logic [IDX_BITS-1:0]   r_idx;
            logic [IDX_BITS-1:0]   r_quot;
            logic [IDX_BITS-1:0]   r_qd;
            logic [IDX_BITS-1:0]   r_part;
            logic [AW-1:0]         r_rem;
            logic [CW-1:0]         r_cnt;
            logic [2*IDX_BITS-1:0] w_prod;
            logic [IDX_BITS-1:0]   w_qd;
            logic [IDX_BITS-1:0]   w_fix;

            // Estimate the quotient by the reciprocal: exact or one short
            assign w_prod = r_idx * RECIP;
            assign w_qd   = r_quot * DEPTH_IDX;
            assign w_fix  = r_part - DEPTH_IDX;

            // Advance the pipeline: quotient, product, partial remainder, fix-up
            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_idx <= i_in_idx;
                end
                r_quot <= w_prod[2*IDX_BITS-1:IDX_BITS];
                r_qd   <= w_qd;
                r_part <= r_idx - r_qd;
                r_rem  <= (r_part >= DEPTH_IDX) ? w_fix[AW-1:0] : r_part[AW-1:0];
            end

            // Count the pipeline stages after a load
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_cmd.load) begin
                    r_cnt <= CW'(4);
                end else if (i_cmd.step && r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end

            assign w_slot     = r_rem;
            assign w_red_done = (r_cnt == '0);
        end
    endgenerate

    // Capture the command and the data word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_cmd;
            r_wdata <= i_in_wdata;
        end
    end

    // Control registers: active copy, sweep pointer, write-back stage
    assign w_ptr_last = (r_ptr == AW'(STORE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ptr    <= '0;
            r_wb_vld <= 1'b0;
        end else begin
            if (i_cmd.flip) begin
                r_active <= ~r_active;
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (i_cmd.sweep || i_cmd.walk) begin
                r_ptr <= w_ptr_last ? '0 : r_ptr + AW'(1);
            end
            r_wb_vld <= i_cmd.walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_ptr;
    end

    // Write and write-back selects
    assign w_wdata    = WORD_BITS'(r_wdata);
    assign w_wr_zero  = i_cmd.access && (r_cmd == CMD_WRITE) && !r_active;
    assign w_wr_one   = i_cmd.access && (r_cmd == CMD_WRITE) && r_active;
    assign w_wb_entry = r_active ? r_q_zero : r_q_one;
    assign w_wb_snap  = r_wb_vld && w_wb_entry[WORD_BITS];
    assign w_wb_zero  = w_wb_snap && r_active;
    assign w_wb_one   = w_wb_snap && !r_active;
    assign w_raddr    = i_cmd.walk ? r_ptr : w_slot;

    // Copy zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem_zero[r_ptr] <= {1'b0, FILL_WORD};
        end else if (w_wr_zero) begin
            r_mem_zero[w_slot] <= {1'b1, w_wdata};
        end else if (w_wb_zero) begin
            r_mem_zero[r_wb_addr] <= {1'b0, r_q_zero[WORD_BITS-1:0]};
        end
        r_q_zero <= r_mem_zero[w_raddr];
    end

    // Copy one
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem_one[r_ptr] <= {1'b0, FILL_WORD};
        end else if (w_wr_one) begin
            r_mem_one[w_slot] <= {1'b1, w_wdata};
        end else if (w_wb_one) begin
            r_mem_one[r_wb_addr] <= {1'b0, r_q_one[WORD_BITS-1:0]};
        end
        r_q_one <= r_mem_one[w_raddr];
    end

    // Snapshot store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem_snap[r_ptr] <= FILL_WORD;
        end else if (w_wb_snap) begin
            r_mem_snap[r_wb_addr] <= w_wb_entry[WORD_BITS-1:0];
        end
        r_q_snap <= r_mem_snap[w_slot];
    end

    // Pick the result word
    always_comb begin
        unique case (r_cmd)
            CMD_READ:       w_result = r_active ? DATA_BITS'(r_q_one[WORD_BITS-1:0])
                                                : DATA_BITS'(r_q_zero[WORD_BITS-1:0]);
            CMD_SNAP_READ:  w_result = DATA_BITS'(r_q_snap);
            CMD_WRITE:      w_result = '0;
            CMD_CHECKPOINT: w_result = '0;
            default:        w_result = '0;
        endcase
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data   <= w_result;
            r_out_active <= r_active;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_data   = r_out_data;
    assign o_out_active = r_out_active;

    assign o_sts.cmd      = r_cmd;
    assign o_sts.red_done = w_red_done;
    assign o_sts.ptr_last = w_ptr_last;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    `PDSS_ASSERT_NEXT(a_flag_hold, i_clk, i_rst_n, !i_cmd.flip, $stable(r_active))
    `PDSS_ASSERT_NEXT(a_out_src, i_clk, i_rst_n, !r_out_vld && !i_cmd.finish, !r_out_vld)
    `PDSS_ASSERT_IMPL(a_no_write_in_walk, i_clk, i_rst_n, i_cmd.walk, !w_wr_zero && !w_wr_one)

endmodule

// ----- sv/pdss_ctrl.sv -----
// Controller: clearing pass, command sequencing, checkpoint walk
`include "pingpong_dirty_snapshot_store_defines.svh"

module pdss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output pdss_pkg::t_dp_cmd o_cmd,
    input  pdss_pkg::t_dp_sts i_sts
);
    import pdss_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_WALK,
        S_WALK_END,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Decode commands and the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_sts.cmd == CMD_CHECKPOINT) begin
                    o_cmd.flip = 1'b1;
                    n_state    = S_WALK;
                end else if (i_sts.red_done) begin
                    o_cmd.access = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_WALK_END;
                end
            end
            S_WALK_END: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `PDSS_ASSERT_IMPL(a_finish_free, i_clk, i_rst_n, o_cmd.finish, i_sts.out_free)
    `PDSS_ASSERT_NEXT(a_walk_end, i_clk, i_rst_n, (r_state == S_WALK) && i_sts.ptr_last, r_state == S_WALK_END)
    `PDSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state == S_REDUCE)

endmodule

// ----- sv/pingpong_dirty_snapshot_store.sv -----
// Top level of the ping-pong dirty snapshot store
// Input words arrive on the s-side stream: tuser carries the command (read active copy,
// write active copy, checkpoint, read snapshot), tdata the index and the write word.
// Each command returns one result word on the m-side stream: read word and active copy.
// The index is reduced modulo STORE_DEPTH: free for a power-of-two depth, otherwise
// a reciprocal multiply with one fix-up step passes through the quotient, product,
// partial remainder and fix-up registers before each read or write. Read or write:
// the slot is accessed once the index is reduced, then the result register is loaded.
// Checkpoint: toggles the active copy, then walks the inactive copy one entry a cycle
// over the single read port of that copy, moving dirty words into the snapshot store;
// the result is loaded after the write-back of the last entry.
// One command is in work at a time; tready is high only while the block waits for one.
// After reset a clearing pass over all STORE_DEPTH entries fills every store with 0x53
// bytes and clears all dirty bits; tready stays low meanwhile.
// A stalled receiver leaves the result in the output register; the next word is still
// taken, and its result waits until the register is free.
module pingpong_dirty_snapshot_store #(
    parameter int STORE_DEPTH = pdss_pkg::DEF_STORE_DEPTH,
    parameter int WORD_BITS   = pdss_pkg::DEF_WORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [30:0] index, [62:31] write_data, [63] zero
    input  logic [pdss_pkg::IN_TDATA_BITS-1:0] i_s_tdata,
    // [1:0] command
    input  logic [pdss_pkg::CMD_BITS-1:0]      i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] read_data, [32] active_copy, [39:33] zero
    output logic [pdss_pkg::OUT_TDATA_BITS-1:0] o_m_tdata
);
    import pdss_pkg::*;

    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    logic [DATA_BITS-1:0] w_out_data;
    logic                 w_out_active;

    pdss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    pdss_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (t_cmd'(i_s_tuser)),
        .i_in_idx     (i_s_tdata[IDX_BITS-1:0]),
        .i_in_wdata   (i_s_tdata[IDX_BITS+DATA_BITS-1:IDX_BITS]),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_data   (w_out_data),
        .o_out_active (w_out_active)
    );

    // Pack the result word
    assign o_m_tdata = {{OUT_PAD_BITS{1'b0}}, w_out_active, w_out_data};

endmodule
